// ----- rtl/msed_pkg.sv -----
package msed_pkg;

	localparam int NUM_SLOTS_DEF = 16;

	localparam logic [4:0] EVT_SYN = 5'd0;
	localparam logic [4:0] EVT_KEY = 5'd1;
	localparam logic [4:0] EVT_ABS = 5'd3;

	localparam logic [9:0] CODE_REPORT    = 10'd0;
	localparam logic [9:0] CODE_TOUCH_KEY = 10'd330;
	localparam logic [9:0] CODE_X         = 10'h000;
	localparam logic [9:0] CODE_Y         = 10'h001;
	localparam logic [9:0] CODE_SLOT      = 10'h02f;
	localparam logic [9:0] CODE_SLOT_X    = 10'h035;
	localparam logic [9:0] CODE_SLOT_Y    = 10'h036;
	localparam logic [9:0] CODE_TRACK     = 10'h039;

	localparam logic signed [31:0] ID_NONE       = -32'sd1;
	localparam logic signed [31:0] ID_PENDING_UP = -32'sd2;

	localparam logic REG_MODE   = 1'b0;
	localparam logic MODE_RESET = 1'b1;

	typedef enum logic [1:0] {
		ACT_DOWN = 2'd0,
		ACT_MOVE = 2'd1,
		ACT_UP   = 2'd2
	} action_t;

	typedef struct packed {
		logic [4:0]         event_type;
		logic [9:0]         event_code;
		logic signed [31:0] event_value;
	} in_word_t;

	typedef struct packed {
		logic [3:0]         slot_index;
		action_t            contact_action;
		logic signed [31:0] contact_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic               last_of_report;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] id;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} slot_row_t;

	localparam slot_row_t ROW_RESET = '{id: ID_NONE, x: 32'sd0, y: 32'sd0};

endpackage

// ----- rtl/msed_slot_ram.sv -----
module msed_slot_ram import msed_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  slot_row_t         wdata,
	input  logic              re,
	input  logic [SLOT_W-1:0] raddr,
	output slot_row_t         rdata
);

	slot_row_t              mem_q [NUM_SLOTS];
	slot_row_t              rd_q;
	logic [NUM_SLOTS-1:0]   written_q;
	logic                   rd_written_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_written_q <= written_q[raddr];
			end
		end
	end

	// unwritten rows read as the reset row
	assign rdata = rd_written_q ? rd_q : ROW_RESET;

endmodule

// ----- rtl/multitouch_slot_event_decoder_core.sv -----
// Slot select and ignored words finish in the idle state; track id, position and touch key words
// read the table, then modify and write back in the modify state.
// Sync report: the scan visits every slot in turn and emits one record per changed live slot;
// a record waits while out_stall holds the output register.
// Throughput: one word at a time; the input stalls until the current word completes.
// Reset: slot table reads as no contact at zero position, mode = slot protocol, slot 0.
module multitouch_slot_event_decoder_core import msed_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MOD  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		K_TRACK = 2'd0,
		K_X     = 2'd1,
		K_Y     = 2'd2,
		K_KEY   = 2'd3
	} kind_t;

	state_t               state_q;
	kind_t                kind_q;
	kind_t                kind_d;
	logic                 mode_q;
	logic                 key_q;
	logic [SLOT_W-1:0]    cur_q;
	logic [SLOT_W-1:0]    addr_q;
	logic [SLOT_W-1:0]    scan_q;
	logic signed [31:0]   val_q;
	logic [NUM_SLOTS-1:0] changed_q;
	logic [NUM_SLOTS-1:0] live_q;
	logic [NUM_SLOTS-1:0] seen_q;
	logic [NUM_SLOTS-1:0] emit_mask;
	logic [NUM_SLOTS-1:0] above;
	out_word_t            out_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 go_mod;
	logic                 go_scan;
	logic                 sel_slot;
	logic [SLOT_W-1:0]    mod_addr;
	logic                 ram_we;
	logic [SLOT_W-1:0]    ram_waddr;
	slot_row_t            ram_wdata;
	logic                 ram_re;
	logic [SLOT_W-1:0]    ram_raddr;
	slot_row_t            ram_rdata;
	slot_row_t            new_row;
	logic                 mod_chg;
	logic                 key_new;
	logic                 out_load;
	logic                 is_up;
	logic                 scan_last;
	logic                 cfg_wr;

	msed_slot_ram #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
	assign prdata   = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// decode the incoming word
	always_comb begin
		go_mod   = 1'b0;
		go_scan  = 1'b0;
		sel_slot = 1'b0;
		kind_d   = K_TRACK;
		mod_addr = cur_q;
		if (in_data.event_type == EVT_ABS) begin
			unique case (in_data.event_code)
				CODE_SLOT: begin
					sel_slot = !in_data.event_value[31] &&
						(in_data.event_value < 32'(NUM_SLOTS));
				end
				CODE_TRACK: begin
					go_mod = 1'b1;
					kind_d = K_TRACK;
				end
				CODE_SLOT_X: begin
					go_mod = 1'b1;
					kind_d = K_X;
				end
				CODE_SLOT_Y: begin
					go_mod = 1'b1;
					kind_d = K_Y;
				end
				CODE_X: begin
					go_mod   = !mode_q;
					kind_d   = K_X;
					mod_addr = '0;
				end
				CODE_Y: begin
					go_mod   = !mode_q;
					kind_d   = K_Y;
					mod_addr = '0;
				end
				default: begin
				end
			endcase
		end else if (in_data.event_type == EVT_KEY) begin
			go_mod   = (in_data.event_code == CODE_TOUCH_KEY) && !mode_q;
			kind_d   = K_KEY;
			mod_addr = '0;
		end else if (in_data.event_type == EVT_SYN) begin
			go_scan = (in_data.event_code == CODE_REPORT);
		end
	end

	// modify the row read for the held word
	always_comb begin
		new_row = ram_rdata;
		mod_chg = 1'b0;
		key_new = (val_q != 32'sd0);
		unique case (kind_q)
			K_TRACK: begin
				if (ram_rdata.id != val_q) begin
					mod_chg    = 1'b1;
					new_row.id = val_q[31] ? ID_PENDING_UP : val_q;
				end
			end
			K_X: begin
				if (ram_rdata.x != val_q) begin
					mod_chg   = 1'b1;
					new_row.x = val_q;
				end
			end
			K_Y: begin
				if (ram_rdata.y != val_q) begin
					mod_chg   = 1'b1;
					new_row.y = val_q;
				end
			end
			K_KEY: begin
				if (key_new != key_q) begin
					mod_chg    = 1'b1;
					new_row.id = key_new ? 32'sd0 : ID_PENDING_UP;
				end
			end
			default: begin
			end
		endcase
	end

	assign emit_mask = changed_q & live_q;

	always_comb begin
		for (int j = 0; j < NUM_SLOTS; j++) begin
			above[j] = (SLOT_W'(j) > scan_q);
		end
	end

	assign scan_last = ~|(emit_mask & above);
	assign is_up     = (ram_rdata.id == ID_PENDING_UP);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mod_addr;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = new_row;
		if (state_q == ST_IDLE) begin
			ram_re = accept && go_mod;
		end else if (state_q == ST_SCAN) begin
			ram_re    = emit_mask[scan_q];
			ram_raddr = scan_q;
		end
		if (state_q == ST_MOD) begin
			ram_we = 1'b1;
		end else if (out_load && is_up) begin
			ram_we       = 1'b1;
			ram_waddr    = scan_q;
			ram_wdata    = ram_rdata;
			ram_wdata.id = ID_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= in_data.event_value;
			kind_q <= kind_d;
			addr_q <= mod_addr;
		end
		if (out_load) begin
			out_q.slot_index     <= 4'(scan_q);
			out_q.contact_action <= is_up ? ACT_UP : (seen_q[scan_q] ? ACT_MOVE : ACT_DOWN);
			out_q.contact_id     <= is_up ? ID_NONE : ram_rdata.id;
			out_q.pos_x          <= ram_rdata.x;
			out_q.pos_y          <= ram_rdata.y;
			out_q.last_of_report <= scan_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_RESET;
			key_q       <= 1'b0;
			cur_q       <= '0;
			scan_q      <= '0;
			changed_q   <= '0;
			live_q      <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				mode_q <= pwdata[0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sel_slot) begin
							cur_q <= in_data.event_value[SLOT_W-1:0];
						end
						if (go_mod) begin
							state_q <= ST_MOD;
						end else if (go_scan) begin
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_MOD: begin
					changed_q[addr_q] <= changed_q[addr_q] | mod_chg;
					live_q[addr_q]    <= (new_row.id != ID_NONE);
					if (kind_q == K_KEY) begin
						key_q <= key_new;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (emit_mask[scan_q]) begin
						state_q <= ST_EMIT;
					end else begin
						// drop changes on empty slots
						changed_q[scan_q] <= 1'b0;
						if (scan_q == LAST_SLOT) begin
							state_q <= ST_IDLE;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						changed_q[scan_q] <= 1'b0;
						if (is_up) begin
							live_q[scan_q] <= 1'b0;
							seen_q[scan_q] <= 1'b0;
						end else begin
							seen_q[scan_q] <= 1'b1;
						end
						if (scan_q == LAST_SLOT) begin
							state_q <= ST_IDLE;
						end else begin
							scan_q  <= scan_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
